@@ rtl/core/dual_timer_with_keyed_watchdog_defines.svh @@
// Assertion macros shared by the timer block RTL.
`ifndef DUAL_TIMER_WITH_KEYED_WATCHDOG_DEFINES_SVH
`define DUAL_TIMER_WITH_KEYED_WATCHDOG_DEFINES_SVH

// Checked at every clk edge outside reset.
`define DTKW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clk edge, reset included.
`define DTKW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dtkw_pkg.sv @@
// Types, register map and constants for the dual timer and keyed watchdog.
`timescale 1ns / 1ps

package dtkw_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    TMR_LOAD = 2'd0,
    TMR_HOLD = 2'd1,
    TMR_RUN  = 2'd2
  } tmr_op_t;

  localparam logic [6:0] A_T0_DIV  = 7'h00;
  localparam logic [6:0] A_T0_DATA = 7'h04;
  localparam logic [6:0] A_T0_CTRL = 7'h08;
  localparam logic [6:0] A_T1_DIV  = 7'h10;
  localparam logic [6:0] A_T1_DATA = 7'h14;
  localparam logic [6:0] A_T1_CTRL = 7'h18;
  localparam logic [6:0] A_TIME    = 7'h38;
  localparam logic [6:0] A_WD_CTRL = 7'h40;
  localparam logic [6:0] A_MASK    = 7'h48;
  localparam logic [6:0] A_ACK     = 7'h4c;
  localparam logic [6:0] A_MASKED  = 7'h54;

  localparam int unsigned WD_CNT_W           = 9;
  localparam logic [8:0]  WD_FULL_COUNT      = 9'd256;
  localparam int unsigned WD_GRACE_TICKS_DEF = 10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  address;
    logic [31:0] write_data;
    logic        tick_timer0;
    logic        tick_timer1;
    logic        tick_watchdog;
    logic        tick_timebase;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        nmi;
    logic        reset_request;
  } out_item_t;

  typedef struct packed {
    logic div_wr;
    logic ctl_wr;
    logic tick;
  } tmr_cmd_t;

  typedef struct packed {
    logic wr;
    logic tick;
  } wd_cmd_t;

  typedef struct packed {
    logic nmi;
    logic rst_req;
  } wd_stat_t;

endpackage

@@ rtl/core/dtkw_timer.sv @@
// One down-counting timer with divisor reload and expiry strobe.
`timescale 1ns / 1ps

module dtkw_timer
  import dtkw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tmr_cmd_t    cmd,
  input  logic [31:0] wdata,
  output logic [31:0] count,
  output logic        fire
);

  logic [31:0] div_r, div_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        run_r, run_nxt;

  always_comb begin
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    fire    = 1'b0;
    if (cmd.div_wr) begin
      div_nxt = wdata;
    end
    if (cmd.ctl_wr) begin
      case (tmr_op_t'(wdata[1:0]))
        TMR_LOAD: cnt_nxt = div_r;
        TMR_HOLD: run_nxt = 1'b0;
        TMR_RUN:  run_nxt = 1'b1;
        default:  ;
      endcase
    end
    if (cmd.tick && run_r) begin
      if (cnt_r <= 32'd1) begin
        cnt_nxt = div_r;
        fire    = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
      cnt_r <= '0;
      run_r <= 1'b0;
    end else begin
      div_r <= div_nxt;
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
    end
  end

  assign count = cnt_r;

endmodule

@@ rtl/core/dtkw_wdog.sv @@
// Keyed watchdog: guarded reload, grace period, nmi and reset request.
`timescale 1ns / 1ps
`include "dual_timer_with_keyed_watchdog_defines.svh"

module dtkw_wdog
  import dtkw_pkg::*;
#(
  parameter int unsigned GraceTicks = WD_GRACE_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  wd_cmd_t     cmd,
  input  logic [15:0] wdata,
  output wd_stat_t    stat
);

  localparam logic [WD_CNT_W-1:0] GraceCnt = WD_CNT_W'(GraceTicks);

  logic [15:0]         ctl_r, ctl_nxt;
  logic [WD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic [1:0]          exp_r, exp_nxt;
  logic                key_ok;

  assign key_ok = !ctl_r[8] || (wdata[15:9] == ~ctl_r[15:9]);

  always_comb begin
    ctl_nxt      = ctl_r;
    cnt_nxt      = cnt_r;
    run_nxt      = run_r;
    exp_nxt      = exp_r;
    stat.rst_req = 1'b0;
    if (cmd.wr && key_ok) begin
      exp_nxt = 2'd0;
      cnt_nxt = (wdata[7:0] == 8'd0) ? WD_FULL_COUNT : {1'b0, wdata[7:0]};
      run_nxt = wdata[8];
      ctl_nxt = wdata;
    end
    if (cmd.tick && run_r) begin
      if (cnt_r <= WD_CNT_W'(1)) begin
        if (exp_r == 2'd0) begin
          cnt_nxt = GraceCnt;
        end else begin
          cnt_nxt      = '0;
          run_nxt      = 1'b0;
          stat.rst_req = 1'b1;
        end
        if (exp_r != 2'd3) begin
          exp_nxt = exp_r + 2'd1;
        end
      end else begin
        cnt_nxt = cnt_r - WD_CNT_W'(1);
      end
    end
    stat.nmi = (exp_nxt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      cnt_r <= '0;
      run_r <= 1'b0;
      exp_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
      exp_r <= exp_nxt;
    end
  end

  `DTKW_ASSERT(a_wd_run_cnt, run_r |-> (cnt_r != '0), "watchdog running with zero count")
  `DTKW_ASSERT(a_wd_stop, stat.rst_req |=> !run_r, "watchdog still running after reset request")
  `DTKW_ASSERT(a_wd_rst_nmi, stat.rst_req |-> stat.nmi, "reset request without nmi")

endmodule

@@ rtl/core/dual_timer_with_keyed_watchdog.sv @@
// Top level: dual timer, keyed watchdog, interrupt logic and register map.
//
//  channel  dir  handshake          payload
//  in_      in   in_valid/in_stall   in_item_t  (read, write or tick)
//  out_     out  out_valid/out_stall out_item_t (one per input transfer)
//
// One transfer in per cycle while in_stall is low; a result is offered
// once its input has passed the input register, then the result register.
// Reset (rst_n low, synchronous) empties both stages and clears all
// state except the item registers.
// out_stall backs up into in_stall only when both stages hold an item.
`timescale 1ns / 1ps
`include "dual_timer_with_keyed_watchdog_defines.svh"

module dual_timer_with_keyed_watchdog
  import dtkw_pkg::*;
#(
  parameter int unsigned WATCHDOG_GRACE_TICKS = WD_GRACE_TICKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  in_item_t    s1_item_r;
  logic        s1_valid_r;
  out_item_t   out_item_r, out_item_nxt;
  logic        out_valid_r;
  logic        out_ready, go;
  logic        is_rd, is_wr, is_tick;
  logic [1:0]  pend_r, pend_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] t0_count, t1_count;
  logic        t0_fire, t1_fire;
  tmr_cmd_t    t0_cmd, t1_cmd;
  wd_cmd_t     wd_cmd;
  wd_stat_t    wd_stat;

  assign out_ready = !out_valid_r || !out_stall;
  assign go        = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;

  assign is_rd   = go && (s1_item_r.operation == OP_READ);
  assign is_wr   = go && (s1_item_r.operation == OP_WRITE);
  assign is_tick = go && (s1_item_r.operation == OP_TICK);

  always_comb begin
    t0_cmd.div_wr = is_wr && (s1_item_r.address == A_T0_DIV);
    t0_cmd.ctl_wr = is_wr && (s1_item_r.address == A_T0_CTRL);
    t0_cmd.tick   = is_tick && s1_item_r.tick_timer0;
    t1_cmd.div_wr = is_wr && (s1_item_r.address == A_T1_DIV);
    t1_cmd.ctl_wr = is_wr && (s1_item_r.address == A_T1_CTRL);
    t1_cmd.tick   = is_tick && s1_item_r.tick_timer1;
    wd_cmd.wr     = is_wr && (s1_item_r.address == A_WD_CTRL);
    wd_cmd.tick   = is_tick && s1_item_r.tick_watchdog;
  end

  dtkw_timer u_timer0 (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (t0_cmd),
    .wdata (s1_item_r.write_data),
    .count (t0_count),
    .fire  (t0_fire)
  );

  dtkw_timer u_timer1 (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (t1_cmd),
    .wdata (s1_item_r.write_data),
    .count (t1_count),
    .fire  (t1_fire)
  );

  dtkw_wdog #(
    .GraceTicks (WATCHDOG_GRACE_TICKS)
  ) u_wdog (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (wd_cmd),
    .wdata (s1_item_r.write_data[15:0]),
    .stat  (wd_stat)
  );

  always_comb begin
    pend_nxt = pend_r | {t1_fire, t0_fire};
    mask_nxt = mask_r;
    time_nxt = time_r;
    if (is_wr && (s1_item_r.address == A_ACK)) begin
      pend_nxt = pend_r & ~s1_item_r.write_data[1:0];
    end
    if (is_wr && (s1_item_r.address == A_MASK)) begin
      mask_nxt = s1_item_r.write_data;
    end
    if (is_tick && s1_item_r.tick_timebase) begin
      time_nxt = time_r + 32'd1;
    end
  end

  always_comb begin
    out_item_nxt.read_data = '0;
    if (is_rd) begin
      case (s1_item_r.address)
        A_T0_DATA: out_item_nxt.read_data = t0_count;
        A_T1_DATA: out_item_nxt.read_data = t1_count;
        A_TIME:    out_item_nxt.read_data = time_r;
        A_MASK:    out_item_nxt.read_data = mask_r;
        A_MASKED:  out_item_nxt.read_data = {30'd0, pend_r & mask_r[1:0]};
        default:   out_item_nxt.read_data = '0;
      endcase
    end
    out_item_nxt.irq           = |(pend_nxt & mask_nxt[1:0]);
    out_item_nxt.nmi           = wd_stat.nmi;
    out_item_nxt.reset_request = wd_stat.rst_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      mask_r      <= '0;
      time_r      <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (go) begin
        s1_valid_r <= 1'b0;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= pend_nxt;
      mask_r <= mask_nxt;
      time_r <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (go) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `DTKW_ASSERT(a_stall_needs_item, !s1_valid_r |-> !in_stall, "stall with empty input stage")
  `DTKW_ASSERT(a_go_fills_out, go |=> out_valid_r, "executed item produced no result")
  `DTKW_ASSERT(a_rst_req_nmi, out_valid_r && out_item_r.reset_request |-> out_item_r.nmi,
               "reset request result without nmi")

endmodule

@@ verif/timer_watchdog_checker.sv @@
// Checker for the dual timer block: predicts each result and compares it with the DUT output.
`timescale 1ns / 1ps

module timer_watchdog_checker
  import dtkw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  output int unsigned mismatches,
  output int unsigned results_seen,
  output int unsigned irq_results,
  output int unsigned nmi_results,
  output int unsigned reset_pulses
);

  typedef struct packed {
    logic [31:0] divisor;
    logic [31:0] count;
    logic        running;
  } timer_state_t;

  timer_state_t tmr [2];
  logic [15:0]  wd_ctrl;
  logic [8:0]   wd_count;
  logic         wd_running;
  logic [1:0]   wd_expiries;
  logic [1:0]   pending;
  logic [31:0]  irq_mask;
  logic [31:0]  time_count;

  out_item_t   predicted_outputs [$];
  int unsigned fail_tally = 0;
  int unsigned seen_tally = 0;
  int unsigned irq_tally = 0;
  int unsigned nmi_tally = 0;
  int unsigned rst_tally = 0;

  task automatic clear_state();
    for (int i = 0; i < 2; i++) begin
      tmr[i] = '0;
    end
    wd_ctrl     = '0;
    wd_count    = '0;
    wd_running  = 1'b0;
    wd_expiries = '0;
    pending     = '0;
    irq_mask    = '0;
    time_count  = '0;
  endtask

  task automatic timer_control(input int idx, input logic [31:0] value);
    case (value[1:0])
      TMR_LOAD: tmr[idx].count = tmr[idx].divisor;
      TMR_HOLD: tmr[idx].running = 1'b0;
      TMR_RUN:  tmr[idx].running = 1'b1;
      default: ;
    endcase
  endtask

  task automatic timer_tick(input int idx);
    if (tmr[idx].running) begin
      if (tmr[idx].count <= 32'd1) begin
        tmr[idx].count = tmr[idx].divisor;
        pending[idx]   = 1'b1;
      end else begin
        tmr[idx].count = tmr[idx].count - 32'd1;
      end
    end
  endtask

  task automatic watchdog_write(input logic [31:0] value);
    if (!wd_ctrl[8] || value[15:9] == ~wd_ctrl[15:9]) begin
      wd_expiries = '0;
      wd_count    = (value[7:0] == 8'd0) ? WD_FULL_COUNT : {1'b0, value[7:0]};
      wd_running  = value[8];
      wd_ctrl     = value[15:0];
    end
  endtask

  task automatic watchdog_tick(output logic rst_pulse);
    rst_pulse = 1'b0;
    if (wd_running) begin
      if (wd_count <= 9'd1) begin
        if (wd_expiries == 2'd0) begin
          wd_count = 9'(WD_GRACE_TICKS_DEF);
        end else begin
          wd_count   = '0;
          wd_running = 1'b0;
          rst_pulse  = 1'b1;
        end
        if (wd_expiries != 2'd3) wd_expiries = wd_expiries + 2'd1;
      end else begin
        wd_count = wd_count - 9'd1;
      end
    end
  endtask

  task automatic predict_outputs(input in_item_t it, output out_item_t res);
    logic rst_pulse;
    rst_pulse = 1'b0;
    res = '0;
    case (it.operation)
      OP_READ: begin
        case (it.address)
          A_T0_DATA: res.read_data = tmr[0].count;
          A_T1_DATA: res.read_data = tmr[1].count;
          A_TIME:    res.read_data = time_count;
          A_MASK:    res.read_data = irq_mask;
          A_MASKED:  res.read_data = {30'd0, pending} & irq_mask;
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (it.address)
          A_T0_DIV:  tmr[0].divisor = it.write_data;
          A_T0_CTRL: timer_control(0, it.write_data);
          A_T1_DIV:  tmr[1].divisor = it.write_data;
          A_T1_CTRL: timer_control(1, it.write_data);
          A_WD_CTRL: watchdog_write(it.write_data);
          A_MASK:    irq_mask = it.write_data;
          A_ACK:     pending = pending & ~it.write_data[1:0];
          default: ;
        endcase
      end
      OP_TICK: begin
        if (it.tick_timer0) timer_tick(0);
        if (it.tick_timer1) timer_tick(1);
        if (it.tick_watchdog) watchdog_tick(rst_pulse);
        if (it.tick_timebase) time_count = time_count + 32'd1;
      end
      default: ;
    endcase
    res.irq           = |({30'd0, pending} & irq_mask);
    res.nmi           = (wd_expiries != 2'd0);
    res.reset_request = rst_pulse;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] %s mismatch: expected %h, got %h", $time, what, want, got);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    out_item_t guess;
    out_item_t want;
    if (!rst_n) begin
      clear_state();
      predicted_outputs.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_outputs(in_item, guess);
        predicted_outputs.push_back(guess);
      end
      if (out_valid && !out_stall) begin
        seen_tally++;
        if (out_item.irq) irq_tally++;
        if (out_item.nmi) nmi_tally++;
        if (out_item.reset_request) rst_tally++;
        if (predicted_outputs.size() == 0) begin
          report_mismatch("unexpected transfer", '0, out_item.read_data);
        end else begin
          want = predicted_outputs.pop_front();
          if (out_item.read_data !== want.read_data) begin
            report_mismatch("read_data", want.read_data, out_item.read_data);
          end
          if (out_item.irq !== want.irq) begin
            report_mismatch("irq", 32'(want.irq), 32'(out_item.irq));
          end
          if (out_item.nmi !== want.nmi) begin
            report_mismatch("nmi", 32'(want.nmi), 32'(out_item.nmi));
          end
          if (out_item.reset_request !== want.reset_request) begin
            report_mismatch("reset_request", 32'(want.reset_request),
                            32'(out_item.reset_request));
          end
        end
      end
    end
    mismatches   <= fail_tally;
    results_seen <= seen_tally;
    irq_results  <= irq_tally;
    nmi_results  <= nmi_tally;
    reset_pulses <= rst_tally;
  end

endmodule

@@ verif/tb_dual_timer_with_keyed_watchdog.sv @@
// Testbench top: drives bus reads, writes, ticks and unused operations into the timer block and reports the verdict.
`timescale 1ns / 1ps

module tb_dual_timer_with_keyed_watchdog
  import dtkw_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [3:0]  TICK_T0      = 4'b1000;
  localparam logic [3:0]  TICK_T1      = 4'b0100;
  localparam logic [3:0]  TICK_WD      = 4'b0010;
  localparam logic [3:0]  TICK_TB      = 4'b0001;
  localparam logic [6:0]  REG_ADDRS [11] = '{A_T0_DIV, A_T0_DATA, A_T0_CTRL, A_T1_DIV,
                                             A_T1_DATA, A_T1_CTRL, A_TIME, A_WD_CTRL,
                                             A_MASK, A_ACK, A_MASKED};

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int unsigned mismatches, results_seen, irq_results, nmi_results, reset_pulses;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned n_reads = 0, n_writes = 0, n_ticks = 0, n_unused = 0;
  logic        sender_calm = 1'b0;
  logic [15:0] wd_shadow = '0;

  dual_timer_with_keyed_watchdog i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  timer_watchdog_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .irq_results  (irq_results),
    .nmi_results  (nmi_results),
    .reset_pulses (reset_pulses)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, results_seen, items_sent);
      $display("** dual_timer_with_keyed_watchdog: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [6:0] addr,
                                         logic [31:0] data, logic [3:0] ticks);
    in_item_t it;
    it = '0;
    it.operation  = op;
    it.address    = addr;
    it.write_data = data;
    {it.tick_timer0, it.tick_timer1, it.tick_watchdog, it.tick_timebase} = ticks;
    return it;
  endfunction

  function automatic logic [31:0] wd_word(logic [6:0] key, logic enable, logic [7:0] count);
    return {16'd0, key, enable, count};
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it = make_item('0, '0, $urandom, 4'($urandom));
    it.address = ($urandom_range(0, 9) == 0) ? 7'($urandom) : REG_ADDRS[$urandom_range(0, 10)];
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.operation = OP_READ;
    end else if (pick < 60) begin
      it.operation = OP_WRITE;
      case (it.address)
        A_T0_DIV, A_T1_DIV: begin
          if ($urandom_range(0, 7) != 0) it.write_data = $urandom_range(0, 12);
        end
        A_WD_CTRL: begin
          if ($urandom_range(0, 4) != 0) it.write_data[15:9] = ~wd_shadow[15:9];
          if ($urandom_range(0, 4) != 0) it.write_data[7:0] = 8'($urandom_range(0, 25));
          it.write_data[8] = ($urandom_range(0, 3) != 0);
        end
        default: ;
      endcase
    end else if (pick < 98) begin
      it.operation     = OP_TICK;
      it.tick_timer0   = ($urandom_range(0, 3) != 0);
      it.tick_timer1   = ($urandom_range(0, 3) != 0);
      it.tick_watchdog = ($urandom_range(0, 3) != 0);
      it.tick_timebase = ($urandom_range(0, 3) != 0);
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send(input in_item_t it);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    case (it.operation)
      OP_READ:  n_reads++;
      OP_WRITE: n_writes++;
      OP_TICK:  n_ticks++;
      default:  n_unused++;
    endcase
    // track the stored key so random writes can supply its complement
    if (it.operation == OP_WRITE && it.address == A_WD_CTRL &&
        (!wd_shadow[8] || it.write_data[15:9] == ~wd_shadow[15:9])) begin
      wd_shadow = it.write_data[15:0];
    end
  endtask

  initial begin : receiver
    int unsigned wait_cycles;
    int unsigned taken;
    logic        calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
      else wait_cycles = calm ? 0 : $urandom_range(0, 6);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send(make_item(OP_READ,  A_T0_DATA, '0, '0));
    send(make_item(OP_WRITE, A_T0_DIV,  32'hFFFF_FFFF, '0));
    send(make_item(OP_WRITE, A_T0_CTRL, 32'(TMR_LOAD), '0));
    send(make_item(OP_READ,  A_T0_DATA, '0, '0));
    send(make_item(OP_WRITE, A_T1_DIV,  32'd0, '0));
    send(make_item(OP_WRITE, A_T1_CTRL, {30'h3FFF_FFFF, TMR_RUN}, '0));
    send(make_item(OP_WRITE, A_T0_CTRL, 32'h0000_0003, '0));
    send(make_item(OP_WRITE, A_MASK,    32'hFFFF_FFFF, '0));
    send(make_item(OP_TICK,  7'h7F, 32'hFFFF_FFFF, TICK_T0 | TICK_T1 | TICK_WD | TICK_TB));
    send(make_item(OP_READ,  A_MASKED,  '0, '0));
    send(make_item(OP_WRITE, A_ACK,     32'hFFFF_FFFF, '0));
    send(make_item(OP_WRITE, 7'h7F,     32'hFFFF_FFFF, '0));
    send(make_item(OP_UNUSED, A_TIME,   32'hFFFF_FFFF, 4'hF));
    send(make_item(OP_READ,  A_TIME,    '0, '0));
    send(make_item(OP_WRITE, A_WD_CTRL, wd_word(7'h55, 1'b1, 8'd1), '0));
    send(make_item(OP_WRITE, A_WD_CTRL, wd_word(7'h55, 1'b1, 8'd200), '0));
    // first expiry, then the grace period runs out
    send(make_item(OP_TICK,  '0, '0, TICK_WD));
    repeat (WD_GRACE_TICKS_DEF) send(make_item(OP_TICK, '0, '0, TICK_WD));
    send(make_item(OP_WRITE, A_WD_CTRL, wd_word(7'h2A, 1'b0, 8'd0), '0));
    send(make_item(OP_TICK,  '0, '0, TICK_WD | TICK_TB));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      send(random_item());
    end
    in_valid <= 1'b0;

    while (results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d reads, %0d writes, %0d tick events and %0d unused operations.",
             n_reads, n_writes, n_ticks, n_unused);
    $display("Checked %0d results: %0d with irq, %0d with nmi, %0d watchdog resets.",
             results_seen, irq_results, nmi_results, reset_pulses);
    if (mismatches == 0) begin
      $display("** dual_timer_with_keyed_watchdog: PASSED **");
    end else begin
      $display("** dual_timer_with_keyed_watchdog: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/dtkw_pkg.sv
rtl/core/dtkw_timer.sv
rtl/core/dtkw_wdog.sv
rtl/core/dual_timer_with_keyed_watchdog.sv
verif/timer_watchdog_checker.sv
verif/tb_dual_timer_with_keyed_watchdog.sv
